### rtl/upd_pkg.sv
`default_nettype none

package upd_pkg;

    localparam logic [7:0] PERCENT_CHAR = 8'h25;
    localparam int         MAX_RESULTS  = 3;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } t_out_item;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_PCT  = 3'b010,
        PH_HEX  = 3'b100
    } t_phase;

    function automatic logic is_hex(input logic [7:0] c);
        return (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
    endfunction

    function automatic logic [3:0] hex_value(input logic [7:0] c);
        logic [3:0] v;
        v = 4'h0;
        if (c inside {[8'h30:8'h39]}) begin
            v = c[3:0];
        end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
            v = c[3:0] + 4'd9;
        end
        return v;
    endfunction

endpackage

`default_nettype wire

### rtl/url_percent_decoder_core.sv
`default_nettype none

// channel | valid   | stall   | payload
// input   | i_valid | o_stall | i_item (t_in_item)
// output  | o_valid | i_stall | o_item (t_out_item)
//
// an item is registered on accept and decoded, once there is room, into 0 to 3 result
// items in a three-entry result buffer that drains one item per cycle while i_stall is
// low; so one item per cycle is sustained while each item yields at most one result;
// an item yielding more holds o_stall until its last result is being sent.
// reset (synchronous, active low) clears the valids, the phase and the held digit.

module url_percent_decoder_core
    import upd_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_valid,
    output logic       o_stall,
    input  t_in_item   i_item,
    output logic       o_valid,
    input  wire        i_stall,
    output t_out_item  o_item
);

    logic       r_in_valid;
    t_in_item   r_in;
    t_phase     r_phase;
    logic [7:0] r_held;
    t_out_item  r_res [MAX_RESULTS];
    logic [1:0] r_cnt;

    t_phase     n_phase;
    logic [7:0] n_held;
    t_out_item  n_res [MAX_RESULTS];
    logic [1:0] n_cnt;

    logic       out_fire;
    logic       space;
    logic       consume;
    logic       in_fire;
    logic [7:0] b;

    assign out_fire = (r_cnt != 2'd0) && !i_stall;
    assign space    = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && out_fire);
    assign consume  = r_in_valid && space;
    assign o_stall  = r_in_valid && !space;
    assign in_fire  = i_valid && !o_stall;
    assign o_valid  = (r_cnt != 2'd0);
    assign o_item   = r_res[0];
    assign b        = r_in.in_byte;

    always_comb begin
        n_phase = PH_IDLE;
        n_held  = r_held;
        n_cnt   = 2'd0;
        for (int k = 0; k < MAX_RESULTS; k++) begin
            n_res[k] = '0;
        end

        case (r_phase)
            PH_PCT: begin
                if (is_hex(b)) begin
                    n_held  = b;
                    n_phase = PH_HEX;
                end else begin
                    n_res[n_cnt] = '{out_byte: PERCENT_CHAR, out_last: 1'b0};
                    n_cnt = n_cnt + 2'd1;
                    if (b == PERCENT_CHAR) begin
                        n_phase = PH_PCT;
                    end else begin
                        n_res[n_cnt] = '{out_byte: b, out_last: 1'b0};
                        n_cnt = n_cnt + 2'd1;
                    end
                end
            end
            PH_HEX: begin
                if (is_hex(b)) begin
                    n_res[n_cnt] = '{out_byte: {hex_value(r_held), hex_value(b)},
                                     out_last: 1'b0};
                    n_cnt = n_cnt + 2'd1;
                end else begin
                    n_res[n_cnt] = '{out_byte: PERCENT_CHAR, out_last: 1'b0};
                    n_cnt = n_cnt + 2'd1;
                    n_res[n_cnt] = '{out_byte: r_held, out_last: 1'b0};
                    n_cnt = n_cnt + 2'd1;
                    if (b == PERCENT_CHAR) begin
                        n_phase = PH_PCT;
                    end else begin
                        n_res[n_cnt] = '{out_byte: b, out_last: 1'b0};
                        n_cnt = n_cnt + 2'd1;
                    end
                end
                n_held = 8'h00;
            end
            default: begin
                if (b == PERCENT_CHAR) begin
                    n_phase = PH_PCT;
                end else begin
                    n_res[n_cnt] = '{out_byte: b, out_last: 1'b0};
                    n_cnt = n_cnt + 2'd1;
                end
            end
        endcase

        if (r_in.in_last) begin
            if (n_phase == PH_PCT) begin
                n_res[n_cnt] = '{out_byte: PERCENT_CHAR, out_last: 1'b0};
                n_cnt = n_cnt + 2'd1;
            end else if (n_phase == PH_HEX) begin
                n_res[n_cnt] = '{out_byte: PERCENT_CHAR, out_last: 1'b0};
                n_cnt = n_cnt + 2'd1;
                n_res[n_cnt] = '{out_byte: n_held, out_last: 1'b0};
                n_cnt = n_cnt + 2'd1;
            end
            n_phase = PH_IDLE;
            n_held  = 8'h00;
            if (n_cnt != 2'd0) begin
                n_res[n_cnt - 2'd1].out_last = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_phase    <= PH_IDLE;
            r_held     <= 8'h00;
            r_cnt      <= 2'd0;
        end else begin
            if (in_fire) begin
                r_in_valid <= 1'b1;
            end else if (consume) begin
                r_in_valid <= 1'b0;
            end
            if (consume) begin
                r_phase <= n_phase;
                r_held  <= n_held;
                r_cnt   <= n_cnt;
            end else if (out_fire) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in <= i_item;
        end
        if (consume) begin
            for (int k = 0; k < MAX_RESULTS; k++) begin
                r_res[k] <= n_res[k];
            end
        end else if (out_fire) begin
            for (int k = 0; k < MAX_RESULTS - 1; k++) begin
                r_res[k] <= r_res[k + 1];
            end
        end
    end

endmodule

`default_nettype wire

### tb/sv/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import upd_pkg::*;

    localparam int         CYCLE_LIMIT = 200000;
    localparam int         DRAIN_LIMIT = 5000;
    localparam int         TAIL_CYCLES = 20;
    localparam int         RANDOM_ITEMS_PER_PHASE = 131;
    localparam logic [7:0] CH_DIGIT0 = 8'h30;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_LOWER_A = 8'h61;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      o_stall;
    t_in_item  i_item = '0;
    logic      o_valid;
    logic      i_stall = 1'b0;
    t_out_item o_item;

    url_percent_decoder_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_item  (i_item),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_item  (o_item)
    );

    int          send_idle_pct = 7;
    int          recv_stall_pct = 70;
    int          items_sent = 0;
    int          error_count = 0;
    int          cycle_count = 0;
    t_out_item   decoded_q[$];
    t_out_item   want_item;
    t_phase      esc_phase = PH_IDLE;
    logic [7:0]  esc_digit = 8'h00;
    logic [7:0]  step_bytes[$];

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("url_percent_decoder_core: mismatch");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("%0t ns: %s: got %02h want %02h", $time, what, got, want);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (decoded_q.size() == 0) begin
                report_mismatch("result with nothing pending", o_item.out_byte, 8'h00);
            end else begin
                want_item = decoded_q.pop_front();
                if (o_item.out_byte !== want_item.out_byte)
                    report_mismatch("out_byte", o_item.out_byte, want_item.out_byte);
                if (o_item.out_last !== want_item.out_last)
                    report_mismatch("out_last", {7'd0, o_item.out_last},
                                    {7'd0, want_item.out_last});
            end
        end
    end

    function automatic logic is_hex_char(input logic [7:0] c);
        logic [7:0] folded;
        folded = c | 8'h20;
        return (c >= CH_DIGIT0 && c <= CH_DIGIT0 + 8'd9) ||
               (folded >= CH_LOWER_A && folded <= CH_LOWER_A + 8'd5);
    endfunction

    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        return (c <= CH_DIGIT0 + 8'd9) ? c[3:0] : c[3:0] + 4'd9;
    endfunction

    // idle-phase handling of one byte
    task automatic take_fresh(input logic [7:0] b);
        if (b == PERCENT_CHAR)
            esc_phase = PH_PCT;
        else
            step_bytes.push_back(b);
    endtask

    task automatic predict_decode(input logic [7:0] b, input logic last);
        step_bytes.delete();
        case (esc_phase)
            PH_PCT: begin
                if (is_hex_char(b)) begin
                    esc_digit = b;
                    esc_phase = PH_HEX;
                end else begin
                    esc_phase = PH_IDLE;
                    step_bytes.push_back(PERCENT_CHAR);
                    take_fresh(b);
                end
            end
            PH_HEX: begin
                esc_phase = PH_IDLE;
                if (is_hex_char(b)) begin
                    step_bytes.push_back({hex_nibble(esc_digit), hex_nibble(b)});
                end else begin
                    step_bytes.push_back(PERCENT_CHAR);
                    step_bytes.push_back(esc_digit);
                    take_fresh(b);
                end
                esc_digit = 8'h00;
            end
            default: begin
                esc_phase = PH_IDLE;
                take_fresh(b);
            end
        endcase
        if (last) begin
            if (esc_phase == PH_PCT) begin
                step_bytes.push_back(PERCENT_CHAR);
            end else if (esc_phase == PH_HEX) begin
                step_bytes.push_back(PERCENT_CHAR);
                step_bytes.push_back(esc_digit);
            end
            esc_phase = PH_IDLE;
            esc_digit = 8'h00;
        end
        foreach (step_bytes[i])
            decoded_q.push_back('{out_byte: step_bytes[i],
                                  out_last: last && (i == step_bytes.size() - 1)});
    endtask

    task automatic send_item(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item <= '{in_byte: b, in_last: last};
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        predict_decode(b, last);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], i == s.len() - 1);
    endtask

    function automatic logic [7:0] rand_hex_char();
        int v;
        v = $urandom_range(15);
        if (v < 10)
            return CH_DIGIT0 + 8'(v);
        return ($urandom_range(1) ? CH_UPPER_A : CH_LOWER_A) + 8'(v - 10);
    endfunction

    function automatic logic [7:0] rand_non_hex();
        logic [7:0] c;
        c = 8'($urandom_range(255));
        while (is_hex_char(c))
            c = 8'($urandom_range(255));
        return c;
    endfunction

    task automatic test_plain_bytes();
        send_item(8'h00, 1'b0);
        send_item(8'hff, 1'b1);
        send_text("%00");
    endtask

    task automatic test_escapes();
        send_text("%fF");
        send_text("%%4a");
    endtask

    task automatic test_broken_escapes();
        send_text("%z");
        send_text("%ag");
        send_text("%9%30");
    endtask

    task automatic test_end_flush();
        send_text("%");
        send_text("%b");
    endtask

    // mostly well-formed escapes and plain bytes, some lone or broken escapes
    task automatic test_random_strings(input int send_pct, input int recv_pct);
        logic [7:0] str_bytes[$];
        int         target;
        int         pick;
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        target = items_sent + RANDOM_ITEMS_PER_PHASE;
        while (items_sent < target) begin
            str_bytes.delete();
            repeat ($urandom_range(1, 8)) begin
                pick = $urandom_range(99);
                if (pick < 45) begin
                    str_bytes.push_back(8'($urandom_range(255)));
                end else if (pick < 85) begin
                    str_bytes.push_back(PERCENT_CHAR);
                    str_bytes.push_back(rand_hex_char());
                    str_bytes.push_back(rand_hex_char());
                end else if (pick < 92) begin
                    str_bytes.push_back(PERCENT_CHAR);
                end else begin
                    str_bytes.push_back(PERCENT_CHAR);
                    str_bytes.push_back(rand_hex_char());
                    str_bytes.push_back(rand_non_hex());
                end
            end
            foreach (str_bytes[i])
                send_item(str_bytes[i], i == str_bytes.size() - 1);
        end
    endtask

    task automatic wait_for_drain();
        int waited;
        i_valid <= 1'b0;
        waited = 0;
        while (decoded_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (decoded_q.size() != 0)
            report_mismatch("results never arrived", 8'h00, decoded_q[0].out_byte);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_plain_bytes();
        test_escapes();
        test_broken_escapes();
        test_end_flush();
        test_random_strings(7, 70);
        test_random_strings(70, 7);
        test_random_strings(0, 0);
        wait_for_drain();
        if (error_count == 0)
            $display("url_percent_decoder_core: match");
        else
            $display("url_percent_decoder_core: mismatch");
        $finish;
    end

endmodule
